### rtl/hav_pkg.sv
// ----------------------------------------------------------------------------
// hav_pkg: shared constants, tables and types for the haversine distance block
// Holds the CORDIC arctangent table, fixed-point constants and the radian
// conversion and Q30 multiply helpers used by several pipeline parts.
// ----------------------------------------------------------------------------
package hav_pkg;

   localparam int LatW = 28;
   localparam int LonW = 29;
   localparam int DistW = 31;
   // signed Q30 datapath width for CORDIC x/y/z
   localparam int QW = 34;

   localparam logic [QW-1:0] CordicGain = 34'd652032874;
   localparam logic [QW-1:0] Q30One = 34'd1073741824;
   localparam logic [29:0] Deg90Half = 30'd180000000;
   localparam logic [29:0] Deg180Half = 30'd360000000;
   localparam logic [35:0] RadPerHalf = 36'd40244552545;
   localparam logic [30:0] EarthDiamCm = 31'd1274200000;
   localparam logic [DistW-1:0] HalfCircCm = 31'd2001508680;

   localparam int CSR_REF_LAT = 0;
   localparam int CSR_REF_LON = 1;

   typedef logic signed [QW-1:0] q30_type;

   typedef struct packed {
      q30_type x;
      q30_type y;
      q30_type z;
   } cordic_vec_type;

   function automatic q30_type atan_q30(input int i);
      logic [29:0] t;
      case (i)
         0: t = 30'd843314857;
         1: t = 30'd497837829;
         2: t = 30'd263043837;
         3: t = 30'd133525159;
         4: t = 30'd67021687;
         5: t = 30'd33543516;
         6: t = 30'd16775851;
         7: t = 30'd8388437;
         8: t = 30'd4194283;
         9: t = 30'd2097149;
         default: t = (i < 31) ? (30'd1 << (30 - i)) : 30'd0;
      endcase
      return q30_type'({4'd0, t});
   endfunction

   // half-microdegree count (0..Deg90Half) to Q30 radians
   function automatic q30_type to_rad(input logic [29:0] u);
      logic [65:0] p;
      p = {36'd0, u} * {30'd0, RadPerHalf} + 66'd2147483648;
      return q30_type'({2'b00, p[63:32]});
   endfunction

   // Q30 product, floor shift with rounding
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic signed [2*QW-1:0] p;
      p = a * b + (2*QW)'(64'sd536870912);
      return q30_type'(p >>> 30);
   endfunction

endpackage

### rtl/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance to a configured reference point
//
//   channel  ports                          handshake
//   req      req_point_lat, req_point_lon   start / busy
//   rsp      rsp_distance_cm                rsp_valid strobe, one cycle
//   csr      csr_index, csr_data            csr_valid / csr_ready
//
// One word enters per cycle; the latency is set by the two CORDIC chains,
// the 31-stage square root and ten other stages.
// busy is always low; csr_ready is always high.
// Synchronous reset clears valid bits and loads the default reference point.
// ----------------------------------------------------------------------------
module haversine_distance #(
   parameter int ANGLE_ITERATIONS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [hav_pkg::LatW-1:0] req_point_lat,
   input  logic signed [hav_pkg::LonW-1:0] req_point_lon,
   output logic rsp_valid,
   output logic [hav_pkg::DistW-1:0] rsp_distance_cm,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [31:0] csr_data
);
   localparam int IT = ANGLE_ITERATIONS;

   logic signed [hav_pkg::LatW-1:0] ref_lat_ff;
   logic signed [hav_pkg::LonW-1:0] ref_lon_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff <= -28'sd19871904;
         ref_lon_ff <= -29'sd43966248;
      end else if (csr_valid) begin
         if (csr_index == 1'(hav_pkg::CSR_REF_LAT)) ref_lat_ff <= csr_data[hav_pkg::LatW-1:0];
         else ref_lon_ff <= csr_data[hav_pkg::LonW-1:0];
      end
   end

   // stage 1: absolute differences and absolute latitudes
   logic s1_vld_ff;
   logic [29:0] s1_dlat_ff, s1_dlon_ff, s1_l1_ff, s1_l2_ff;
   logic [29:0] dlat_in, dlon_in, l1_in, l2_in;
   always_comb begin
      logic signed [29:0] dla, dlo, a1, a2;
      dla = 30'(ref_lat_ff) - 30'(req_point_lat);
      dlo = 30'(ref_lon_ff) - 30'(req_point_lon);
      a1 = 30'(req_point_lat);
      a2 = 30'(ref_lat_ff);
      dlat_in = dla[29] ? 30'(-dla) : dla;
      dlon_in = dlo[29] ? 30'(-dlo) : dlo;
      l1_in = a1[29] ? 30'(-a1) : a1;
      l2_in = a2[29] ? 30'(-a2) : a2;
   end
   always_ff @(posedge clock) begin
      s1_dlat_ff <= dlat_in;
      s1_dlon_ff <= dlon_in;
      s1_l1_ff <= l1_in;
      s1_l2_ff <= l2_in;
      if (reset) s1_vld_ff <= 1'b0;
      else s1_vld_ff <= start;
   end

   // stage 2: reduce modulo 180 deg (|d| < 3*Deg180Half), fold to 0..90; double and fold latitudes
   function automatic logic [29:0] fold_diff(input logic [29:0] d);
      logic [29:0] h;
      h = d;
      if (h >= hav_pkg::Deg180Half) h = h - hav_pkg::Deg180Half;
      if (h >= hav_pkg::Deg180Half) h = h - hav_pkg::Deg180Half;
      if (h > hav_pkg::Deg90Half) h = hav_pkg::Deg180Half - h;
      return h;
   endfunction
   function automatic logic [30:0] fold_lat(input logic [29:0] l);
      logic [30:0] u;
      u = {l, 1'b0};
      if (u > 31'(hav_pkg::Deg90Half)) return {1'b1, 30'(31'(hav_pkg::Deg180Half) - u)};
      return {1'b0, u[29:0]};
   endfunction

   logic s2_vld_ff;
   logic [29:0] s2_hlat_ff, s2_hlon_ff, s2_u1_ff, s2_u2_ff;
   logic s2_n1_ff, s2_n2_ff;
   always_ff @(posedge clock) begin
      s2_hlat_ff <= fold_diff(s1_dlat_ff);
      s2_hlon_ff <= fold_diff(s1_dlon_ff);
      {s2_n1_ff, s2_u1_ff} <= fold_lat(s1_l1_ff);
      {s2_n2_ff, s2_u2_ff} <= fold_lat(s1_l2_ff);
      if (reset) s2_vld_ff <= 1'b0;
      else s2_vld_ff <= s1_vld_ff;
   end

   // stage 3: to Q30 radians
   logic s3_vld_ff, s3_n1_ff, s3_n2_ff;
   hav_pkg::q30_type s3_zlat_ff, s3_zlon_ff, s3_z1_ff, s3_z2_ff;
   always_ff @(posedge clock) begin
      s3_zlat_ff <= hav_pkg::to_rad(s2_hlat_ff);
      s3_zlon_ff <= hav_pkg::to_rad(s2_hlon_ff);
      s3_z1_ff <= hav_pkg::to_rad(s2_u1_ff);
      s3_z2_ff <= hav_pkg::to_rad(s2_u2_ff);
      s3_n1_ff <= s2_n1_ff;
      s3_n2_ff <= s2_n2_ff;
      if (reset) s3_vld_ff <= 1'b0;
      else s3_vld_ff <= s2_vld_ff;
   end

   logic r_vld;
   logic [1:0] r_side;
   hav_pkg::q30_type s_lat, s_lon, c_1, c_2;

   hav_rotate #(.ITER(IT), .SW(2)) u_rot_lat (
      .clock, .reset, .in_valid(s3_vld_ff), .in_angle(s3_zlat_ff),
      .in_side({s3_n1_ff, s3_n2_ff}), .out_valid(r_vld), .out_cos(),
      .out_sin(s_lat), .out_side(r_side));
   hav_rotate #(.ITER(IT), .SW(1)) u_rot_lon (
      .clock, .reset, .in_valid(s3_vld_ff), .in_angle(s3_zlon_ff), .in_side(1'b0),
      .out_valid(), .out_cos(), .out_sin(s_lon), .out_side());
   hav_rotate #(.ITER(IT), .SW(1)) u_rot_l1 (
      .clock, .reset, .in_valid(s3_vld_ff), .in_angle(s3_z1_ff), .in_side(1'b0),
      .out_valid(), .out_cos(c_1), .out_sin(), .out_side());
   hav_rotate #(.ITER(IT), .SW(1)) u_rot_l2 (
      .clock, .reset, .in_valid(s3_vld_ff), .in_angle(s3_z2_ff), .in_side(1'b0),
      .out_valid(), .out_cos(c_2), .out_sin(), .out_side());

   // stage 4: squares of sines, signed cosines
   logic s4_vld_ff;
   hav_pkg::q30_type s4_sl_ff, s4_so_ff, s4_c1_ff, s4_c2_ff;
   always_ff @(posedge clock) begin
      s4_sl_ff <= hav_pkg::mul_q30(s_lat, s_lat);
      s4_so_ff <= hav_pkg::mul_q30(s_lon, s_lon);
      s4_c1_ff <= r_side[1] ? -c_1 : c_1;
      s4_c2_ff <= r_side[0] ? -c_2 : c_2;
      if (reset) s4_vld_ff <= 1'b0;
      else s4_vld_ff <= r_vld;
   end

   // stage 5: cos product
   logic s5_vld_ff;
   hav_pkg::q30_type s5_sl_ff, s5_so_ff, s5_cc_ff;
   always_ff @(posedge clock) begin
      s5_sl_ff <= s4_sl_ff;
      s5_so_ff <= s4_so_ff;
      s5_cc_ff <= hav_pkg::mul_q30(s4_c1_ff, s4_c2_ff);
      if (reset) s5_vld_ff <= 1'b0;
      else s5_vld_ff <= s4_vld_ff;
   end

   // stage 6: weighted term
   logic s6_vld_ff;
   hav_pkg::q30_type s6_sl_ff, s6_t_ff;
   always_ff @(posedge clock) begin
      s6_sl_ff <= s5_sl_ff;
      s6_t_ff <= hav_pkg::mul_q30(s5_so_ff, s5_cc_ff);
      if (reset) s6_vld_ff <= 1'b0;
      else s6_vld_ff <= s5_vld_ff;
   end

   // stage 7: sum and clamp to 0..1
   logic s7_vld_ff;
   logic [30:0] s7_a_ff;
   logic [30:0] a_in;
   always_comb begin
      hav_pkg::q30_type sum;
      sum = s6_sl_ff + s6_t_ff;
      if (sum[hav_pkg::QW-1]) a_in = '0;
      else if (sum > hav_pkg::Q30One) a_in = 31'(hav_pkg::Q30One);
      else a_in = sum[30:0];
   end
   always_ff @(posedge clock) begin
      s7_a_ff <= a_in;
      if (reset) s7_vld_ff <= 1'b0;
      else s7_vld_ff <= s6_vld_ff;
   end

   logic [30:0] root_y, root_x;
   logic [30:0] one_m_a;
   logic [30:0] sq_vld_ff;
   assign one_m_a = 31'(hav_pkg::Q30One) - s7_a_ff;

   hav_isqrt u_sqrt_y (.clock, .in_n({s7_a_ff, 31'd0} >> 1), .out_root(root_y));
   hav_isqrt u_sqrt_x (.clock, .in_n({one_m_a, 31'd0} >> 1), .out_root(root_x));

   always_ff @(posedge clock) begin
      if (reset) sq_vld_ff <= '0;
      else sq_vld_ff <= {sq_vld_ff[29:0], s7_vld_ff};
   end

   hav_vector #(.ITER(IT)) u_vec (
      .clock, .reset, .in_valid(sq_vld_ff[30]),
      .in_x(hav_pkg::q30_type'({3'd0, root_x})),
      .in_y(hav_pkg::q30_type'({3'd0, root_y})),
      .out_valid(rsp_valid), .out_dist(rsp_distance_cm));
endmodule

### rtl/hav_rotate.sv
// ----------------------------------------------------------------------------
// hav_rotate: pipelined rotation-mode CORDIC, one register stage per step
// Carries a valid bit and a small sideband word alongside the vector.
// ----------------------------------------------------------------------------
module hav_rotate #(
   parameter int ITER = 24,
   parameter int SW = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  hav_pkg::q30_type in_angle,
   input  logic [SW-1:0] in_side,
   output logic out_valid,
   output hav_pkg::q30_type out_cos,
   output hav_pkg::q30_type out_sin,
   output logic [SW-1:0] out_side
);
   hav_pkg::cordic_vec_type v_first;
   hav_pkg::cordic_vec_type v_ff [1:ITER];
   logic [SW-1:0] side_ff [1:ITER];
   logic [ITER:1] vld_ff;

   always_comb begin
      v_first.x = hav_pkg::CordicGain;
      v_first.y = '0;
      v_first.z = in_angle;
   end

   for (genvar i = 0; i < ITER; i++) begin : g_step
      hav_pkg::cordic_vec_type v_cur, v_in;
      logic [SW-1:0] side_cur;
      logic vld_cur;
      if (i == 0) begin : g_head
         assign v_cur = v_first;
         assign side_cur = in_side;
         assign vld_cur = in_valid;
      end else begin : g_tail
         assign v_cur = v_ff[i];
         assign side_cur = side_ff[i];
         assign vld_cur = vld_ff[i];
      end
      always_comb begin
         if (!v_cur.z[hav_pkg::QW-1]) begin
            v_in.x = v_cur.x - (v_cur.y >>> i);
            v_in.y = v_cur.y + (v_cur.x >>> i);
            v_in.z = v_cur.z - hav_pkg::atan_q30(i);
         end else begin
            v_in.x = v_cur.x + (v_cur.y >>> i);
            v_in.y = v_cur.y - (v_cur.x >>> i);
            v_in.z = v_cur.z + hav_pkg::atan_q30(i);
         end
      end
      always_ff @(posedge clock) begin
         v_ff[i+1] <= v_in;
         side_ff[i+1] <= side_cur;
         if (reset) vld_ff[i+1] <= 1'b0;
         else vld_ff[i+1] <= vld_cur;
      end
   end

   assign out_valid = vld_ff[ITER];
   assign out_cos = v_ff[ITER].x;
   assign out_sin = v_ff[ITER].y;
   assign out_side = side_ff[ITER];
endmodule

### rtl/hav_isqrt.sv
// ----------------------------------------------------------------------------
// hav_isqrt: pipelined floor square root of a 62-bit value, one result bit a stage
// ----------------------------------------------------------------------------
module hav_isqrt (
   input  logic clock,
   input  logic [61:0] in_n,
   output logic [30:0] out_root
);
   localparam int N = 31;
   logic [61:0] rem_ff [1:N];
   logic [30:0] root_ff [1:N];

   for (genvar i = 0; i < N; i++) begin : g_bit
      localparam int B = N - 1 - i;
      logic [61:0] trial;
      logic [30:0] cand;
      logic [61:0] rem_cur;
      logic [30:0] root_cur;
      if (i == 0) begin : g_head
         assign rem_cur = in_n;
         assign root_cur = '0;
      end else begin : g_tail
         assign rem_cur = rem_ff[i];
         assign root_cur = root_ff[i];
      end
      always_comb begin
         cand = root_cur | (31'd1 << B);
         trial = 62'({31'd0, cand} * {31'd0, cand});
      end
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= rem_cur;
         root_ff[i+1] <= (trial <= rem_cur) ? cand : root_cur;
      end
   end

   assign out_root = root_ff[N];
endmodule

### rtl/hav_vector.sv
// ----------------------------------------------------------------------------
// hav_vector: pipelined vectoring-mode CORDIC giving the arc angle, then
// scaling to centimeters with saturation.
// ----------------------------------------------------------------------------
module hav_vector #(
   parameter int ITER = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  hav_pkg::q30_type in_x,
   input  hav_pkg::q30_type in_y,
   output logic out_valid,
   output logic [hav_pkg::DistW-1:0] out_dist
);
   hav_pkg::cordic_vec_type v_first;
   hav_pkg::cordic_vec_type v_ff [1:ITER];
   logic [ITER:1] vld_ff;
   logic [31:0] z_ff;
   logic z_vld_ff;
   logic [62:0] prod_ff;
   logic prod_vld_ff;
   logic [hav_pkg::DistW-1:0] dist_ff;
   logic dist_vld_ff;

   always_comb begin
      v_first.x = in_x;
      v_first.y = in_y;
      v_first.z = '0;
   end

   for (genvar i = 0; i < ITER; i++) begin : g_step
      hav_pkg::cordic_vec_type v_cur, v_in;
      logic vld_cur;
      if (i == 0) begin : g_head
         assign v_cur = v_first;
         assign vld_cur = in_valid;
      end else begin : g_tail
         assign v_cur = v_ff[i];
         assign vld_cur = vld_ff[i];
      end
      always_comb begin
         if (!v_cur.y[hav_pkg::QW-1]) begin
            v_in.x = v_cur.x + (v_cur.y >>> i);
            v_in.y = v_cur.y - (v_cur.x >>> i);
            v_in.z = v_cur.z + hav_pkg::atan_q30(i);
         end else begin
            v_in.x = v_cur.x - (v_cur.y >>> i);
            v_in.y = v_cur.y + (v_cur.x >>> i);
            v_in.z = v_cur.z - hav_pkg::atan_q30(i);
         end
      end
      always_ff @(posedge clock) begin
         v_ff[i+1] <= v_in;
         if (reset) vld_ff[i+1] <= 1'b0;
         else vld_ff[i+1] <= vld_cur;
      end
   end

   logic [62:0] prod_in;
   logic [33:0] d_in;
   always_comb begin
      prod_in = {31'd0, z_ff} * {32'd0, hav_pkg::EarthDiamCm} + 63'd536870912;
      d_in = prod_ff[63-1:30] > 33'({2'b0, hav_pkg::HalfCircCm})
           ? {3'd0, hav_pkg::HalfCircCm} : {1'b0, prod_ff[62:30]};
   end

   always_ff @(posedge clock) begin
      // negative angle clamps to zero
      z_ff <= v_ff[ITER].z[hav_pkg::QW-1] ? '0 : v_ff[ITER].z[31:0];
      prod_ff <= prod_in;
      dist_ff <= d_in[hav_pkg::DistW-1:0];
      if (reset) begin
         z_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         dist_vld_ff <= 1'b0;
      end else begin
         z_vld_ff <= vld_ff[ITER];
         prod_vld_ff <= z_vld_ff;
         dist_vld_ff <= prod_vld_ff;
      end
   end

   assign out_valid = dist_vld_ff;
   assign out_dist = dist_ff;
endmodule

### rtl/haversine_distance_checker.sv
// ----------------------------------------------------------------------------
// haversine_distance_checker: port-level checks on the distance block
// ----------------------------------------------------------------------------
module haversine_distance_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic [30:0] rsp_distance_cm,
   input logic csr_ready
);
   a_no_busy: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance_cm <= 31'd2001508680)
      else $error("distance above half circumference");
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word out after reset");
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");
endmodule

bind haversine_distance haversine_distance_checker u_chk (
   .clock, .reset, .busy, .rsp_valid, .rsp_distance_cm, .csr_ready);

### tb/haversine_distance_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_test: self-checking bench for the haversine distance block
// Streams query points against several reference points and compares every
// distance with a fixed-point model of the CORDIC/isqrt datapath.
// ----------------------------------------------------------------------------
module haversine_distance_test;

   localparam int Iters = 24;
   localparam int Latency = 2 * Iters + 41;
   localparam int LatMax = 90000000;
   localparam int LonMax = 180000000;

   localparam longint ArcTan[0:31] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   class distance_scoreboard;
      longint ref_lat_ud;
      longint ref_lon_ud;
      logic [hav_pkg::DistW-1:0] pending[$];
      int n_checked;
      int n_errors;

      function new();
         ref_lat_ud = -19871904;
         ref_lon_ud = -43966248;
         n_checked = 0;
         n_errors = 0;
      endfunction

      function longint sign_ext(logic [31:0] v, int w);
         longint t;
         t = longint'(v) & ((64'sd1 <<< w) - 1);
         if (t[w-1]) t = t - (64'sd1 <<< w);
         return t;
      endfunction

      function void set_reg(logic [0:0] idx, logic [31:0] data);
         if (idx == hav_pkg::CSR_REF_LAT) ref_lat_ud = sign_ext(data, hav_pkg::LatW);
         else ref_lon_ud = sign_ext(data, hav_pkg::LonW);
      endfunction

      function longint qmul(longint a, longint b);
         return (a * b + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint half_udeg_to_rad(longint unsigned u);
         return longint'((u * 64'd40244552545 + (64'd1 << 31)) >> 32);
      endfunction

      function void sin_cos(longint z, output longint c, output longint s);
         longint x, y, dx, dy;
         x = 652032874;
         y = 0;
         for (int i = 0; i < Iters; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ArcTan[i];
            end else begin
               x += dx; y -= dy; z += ArcTan[i];
            end
         end
         c = x;
         s = y;
      endfunction

      // d in microdegrees doubles as half-angle in half-microdegrees
      function longint half_sin_sq(longint d);
         longint unsigned h;
         longint c, s;
         h = longint'(d < 0 ? -d : d) % 360000000;
         if (h > 180000000) h = 360000000 - h;
         sin_cos(half_udeg_to_rad(h), c, s);
         if (s < 0) s = -s;
         return (s * s + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function longint lat_cosine(longint lat);
         longint unsigned u;
         longint c, s;
         bit flip;
         u = 2 * (lat < 0 ? -lat : lat);
         flip = 0;
         if (u > 180000000) begin
            u = 360000000 - u;
            flip = 1;
         end
         sin_cos(half_udeg_to_rad(u), c, s);
         return flip ? -c : c;
      endfunction

      function void note_point(logic [hav_pkg::LatW-1:0] plat,
                               logic [hav_pkg::LonW-1:0] plon);
         longint lat1, lon1, a, x, y, z, dx, dy;
         longint unsigned d;
         lat1 = sign_ext(32'(plat), hav_pkg::LatW);
         lon1 = sign_ext(32'(plon), hav_pkg::LonW);
         a = half_sin_sq(ref_lat_ud - lat1) +
             qmul(half_sin_sq(ref_lon_ud - lon1),
                  qmul(lat_cosine(lat1), lat_cosine(ref_lat_ud)));
         if (a < 0) a = 0;
         if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
         y = longint'(int_sqrt(longint'(a) << 30));
         x = longint'(int_sqrt(longint'((64'sd1 <<< 30) - a) << 30));
         z = 0;
         for (int i = 0; i < Iters; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += ArcTan[i];
            end else begin
               x -= dx; y += dy; z -= ArcTan[i];
            end
         end
         if (z < 0) z = 0;
         d = (64'd1274200000 * longint'(z) + (64'd1 << 29)) >> 30;
         if (d > 2001508680) d = 2001508680;
         pending.push_back(d[hav_pkg::DistW-1:0]);
      endfunction

      function void check_distance(logic [hav_pkg::DistW-1:0] got);
         logic [hav_pkg::DistW-1:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected distance word, expected none, got %0d",
                     $realtime, got);
            n_errors++;
            return;
         end
         want = pending.pop_front();
         n_checked++;
         if (got !== want) begin
            $display("%0t: distance_cm mismatch, expected %0d, got %0d",
                     $realtime, want, got);
            n_errors++;
         end
      endfunction
   endclass

   logic clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   logic signed [hav_pkg::LatW-1:0] req_point_lat;
   logic signed [hav_pkg::LonW-1:0] req_point_lon;
   logic [hav_pkg::DistW-1:0] rsp_distance_cm;
   logic [0:0] csr_index;
   logic [31:0] csr_data;

   distance_scoreboard sb = new();
   bit calm;
   int n_points;

   haversine_distance #(.ANGLE_ITERATIONS(Iters)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_lat(req_point_lat), .req_point_lon(req_point_lon),
      .rsp_valid(rsp_valid), .rsp_distance_cm(rsp_distance_cm),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data));

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_point(req_point_lat, req_point_lon);
            n_points++;
         end
         if (csr_valid && csr_ready) sb.set_reg(csr_index, csr_data);
         if (rsp_valid) sb.check_distance(rsp_distance_cm);
      end
   end

   task automatic send_point(int plat, int plon);
      while (!calm && $urandom_range(99) < 36) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_point_lat <= hav_pkg::LatW'(plat);
      req_point_lon <= hav_pkg::LonW'(plon);
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      wait (sb.pending.size() == 0);
      repeat (Latency + 10) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_span(int lim);
      return int'($urandom_range(2 * lim)) - lim;
   endfunction

   task automatic random_points(int count);
      int plat, plon;
      int rlat, rlon;
      for (int k = 0; k < count; k++) begin
         calm = (k >= count / 3 && k < count / 2);
         rlat = int'(sb.ref_lat_ud);
         rlon = int'(sb.ref_lon_ud);
         case ($urandom_range(9))
            0, 1: begin // raw bit patterns, out of range included
               plat = int'($urandom);
               plon = int'($urandom);
            end
            2: begin // close to the reference point
               plat = rlat + rand_span(2000);
               plon = rlon + rand_span(2000);
            end
            3: begin // near the antipode, drives saturation
               plat = -rlat + rand_span(50);
               plon = (rlon > 0) ? rlon - LonMax : rlon + LonMax;
               plon += rand_span(50);
            end
            4: begin // poles and the date line
               plat = $urandom_range(1) ? LatMax : -LatMax;
               plon = $urandom_range(1) ? LonMax : -LonMax;
               plon += rand_span(3);
            end
            default: begin
               plat = rand_span(LatMax);
               plon = rand_span(LonMax);
            end
         endcase
         send_point(plat, plon);
      end
      calm = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_point_lat = '0;
      req_point_lon = '0;
      calm = 1'b0;
      n_points = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed points against the default reference
      send_point(0, 0);
      send_point(-19871904, -43966248);
      send_point(19871904, 136033752);
      send_point(19871904, 136033700);
      send_point(LatMax, LonMax);
      send_point(-LatMax, -LonMax);
      send_point(LatMax, 0);
      send_point(-LatMax, 0);
      send_point(0, LonMax);
      send_point(0, -LonMax);
      send_point((1 << 27) - 1, (1 << 28) - 1);
      send_point(-(1 << 27), -(1 << 28));
      send_point(-19871904, -43966248 + 360000000 - (1 << 29));
      send_point(-1, 1);
      random_points(200);

      // pause until the pipeline is empty before streaming on
      drain();
      random_points(40);
      drain();

      write_reg(1'(hav_pkg::CSR_REF_LAT), LatMax);
      write_reg(1'(hav_pkg::CSR_REF_LON), LonMax);
      send_point(-LatMax, -LonMax);
      send_point(LatMax, LonMax);
      random_points(220);
      drain();
      write_reg(1'(hav_pkg::CSR_REF_LAT), -LatMax);
      write_reg(1'(hav_pkg::CSR_REF_LON), -LonMax);
      random_points(220);
      drain();
      write_reg(1'(hav_pkg::CSR_REF_LAT), 0);
      write_reg(1'(hav_pkg::CSR_REF_LON), 0);
      send_point(0, LonMax);
      random_points(220);
      drain();
      write_reg(1'(hav_pkg::CSR_REF_LAT), $urandom);
      write_reg(1'(hav_pkg::CSR_REF_LON), $urandom);
      random_points(220);
      drain();
      write_reg(1'(hav_pkg::CSR_REF_LAT), 32'(rand_span(LatMax)));
      write_reg(1'(hav_pkg::CSR_REF_LON), 32'(rand_span(LonMax)));
      random_points(260);
      drain();

      $display("Covered %0d query points over six reference points, %0d distances checked.",
               n_points, sb.n_checked);
      if (sb.n_errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d distances outstanding", sb.pending.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
